/* sv/lzs_pkg.sv */
// shared constants, state encoding and control types for the zero-sum span finder
package lzs_pkg;

	// default sizing
	localparam int MAX_LEN_DEF    = 64;
	localparam int VALUE_BITS_DEF = 16;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_BEST,
		ST_EMIT_START,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_OUT
	} lzs_state_t;

	// control from the sequencer to the prefix sum table
	typedef struct packed {
		logic wr_en;
		logic clear;
	} lzs_key_ctrl_t;

endpackage

/* sv/lzs_key_table.sv */
// prefix sum table: key memory, per-entry valid flags and the shared key comparator
module lzs_key_table #(
	parameter int DEPTH    = lzs_pkg::MAX_LEN_DEF,
	parameter int IDX_BITS = 6,
	parameter int KEY_BITS = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lzs_pkg::lzs_key_ctrl_t ctrl,
	input  logic [IDX_BITS-1:0]  wr_addr,
	input  logic [KEY_BITS-1:0]  wr_key,
	input  logic [IDX_BITS-1:0]  rd_addr,
	input  logic [KEY_BITS-1:0]  probe_key,
	output logic                 hit
);

	logic [KEY_BITS-1:0] key_mem [DEPTH];
	logic [DEPTH-1:0]    valid_q;
	logic [KEY_BITS-1:0] rd_key_q;
	logic                rd_valid_q;

	// key memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		rd_key_q <= key_mem[rd_addr];
	end

	// valid flags, cleared at once between arrays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= '0;
			end else if (ctrl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// compare the entry read last cycle against the current prefix sum
	assign hit = rd_valid_q && (rd_key_q == probe_key);

endmodule

/* sv/lzs_elem_store.sv */
// element store: one write port and one registered read port
module lzs_elem_store #(
	parameter int DEPTH     = lzs_pkg::MAX_LEN_DEF,
	parameter int IDX_BITS  = 6,
	parameter int DATA_BITS = lzs_pkg::VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_BITS-1:0]  wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic [IDX_BITS-1:0]  rd_addr,
	output logic [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [DATA_BITS-1:0] rd_data_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/longest_zero_sum_subarray.sv */
// Longest zero-sum span finder. An element passes UPDATE, up to i table probes in SCAN
// (i = its index; none on a zero prefix sum, the scan stops at a hit) and BEST, one
// compare per cycle in the scan. An element past MAX_LEN is taken but not stored. Emission:
// EMIT_START, then EMIT_RD, EMIT_LD and EMIT_OUT per span element (registered store read), or
// EMIT_OUT alone for the not-found request, with each result held while out_stall is high.
// Asynchronous reset (arst_n low) clears sequencer, sum, count, best span, table valid flags.
module longest_zero_sum_subarray #(
	parameter int MAX_LEN    = lzs_pkg::MAX_LEN_DEF,
	parameter int VALUE_BITS = lzs_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [VALUE_BITS-1:0] value_res,
	output logic                         found,
	output logic                         end_of_run
);

	localparam int IDX_BITS = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_BITS = $clog2(MAX_LEN + 1);
	localparam int SUM_BITS = VALUE_BITS + $clog2(MAX_LEN);
	localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_LEN);
	localparam logic [CNT_BITS-1:0] ONE_CNT = CNT_BITS'(1);

	lzs_pkg::lzs_state_t state_q, state_d;

	logic [SUM_BITS-1:0]   sum_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   best_q;
	logic [IDX_BITS-1:0]   best_end_q;
	logic                  last_q;
	logic                  has_q;
	logic [CNT_BITS-1:0]   len_q;
	logic [IDX_BITS-1:0]   k_q;
	logic [IDX_BITS-1:0]   ptr_q;
	logic [VALUE_BITS-1:0] value_res_q;
	logic                  found_q;
	logic                  eor_q;

	logic                  in_acc;
	logic                  out_acc;
	logic                  room;
	logic [IDX_BITS-1:0]   cur_idx;
	logic [CNT_BITS-1:0]   k_next;
	logic                  sum_zero;
	logic                  hit;
	logic [IDX_BITS-1:0]   key_rd_addr;
	logic                  key_ins;
	lzs_pkg::lzs_key_ctrl_t key_ctrl;
	logic                  elem_we;
	logic [VALUE_BITS-1:0] elem_rd_data;
	logic [SUM_BITS-1:0]   value_ext;
	logic [CNT_BITS-1:0]   start_cnt;

	// handshake and shared terms
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign room      = (count_q < MAX_CNT);
	assign cur_idx   = count_q[IDX_BITS-1:0];
	assign k_next    = CNT_BITS'(k_q) + ONE_CNT;
	assign sum_zero  = (sum_q == '0);
	assign value_ext = {{(SUM_BITS-VALUE_BITS){value[VALUE_BITS-1]}}, value};
	assign start_cnt = CNT_BITS'(best_end_q) + ONE_CNT - best_q;

	// table insert when the current nonzero prefix sum has not been seen
	always_comb begin
		key_ins = 1'b0;
		if (state_q == lzs_pkg::ST_UPDATE) begin
			key_ins = !sum_zero && (count_q == '0);
		end else if (state_q == lzs_pkg::ST_SCAN) begin
			key_ins = !hit && (k_next == count_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lzs_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (room) begin
						state_d = lzs_pkg::ST_UPDATE;
					end else if (last) begin
						state_d = lzs_pkg::ST_EMIT_START;
					end
				end
			end
			lzs_pkg::ST_UPDATE: begin
				if (sum_zero || count_q == '0) begin
					state_d = lzs_pkg::ST_BEST;
				end else begin
					state_d = lzs_pkg::ST_SCAN;
				end
			end
			lzs_pkg::ST_SCAN: begin
				if (hit || k_next == count_q) begin
					state_d = lzs_pkg::ST_BEST;
				end
			end
			lzs_pkg::ST_BEST: begin
				state_d = last_q ? lzs_pkg::ST_EMIT_START : lzs_pkg::ST_IDLE;
			end
			lzs_pkg::ST_EMIT_START: begin
				state_d = (best_q == '0) ? lzs_pkg::ST_EMIT_OUT : lzs_pkg::ST_EMIT_RD;
			end
			lzs_pkg::ST_EMIT_RD: begin
				state_d = lzs_pkg::ST_EMIT_LD;
			end
			lzs_pkg::ST_EMIT_LD: begin
				state_d = lzs_pkg::ST_EMIT_OUT;
			end
			lzs_pkg::ST_EMIT_OUT: begin
				if (!out_stall) begin
					state_d = eor_q ? lzs_pkg::ST_IDLE : lzs_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = lzs_pkg::ST_IDLE;
			end
		endcase
	end

	// state-decoded outputs and memory controls
	always_comb begin
		in_stall       = (state_q != lzs_pkg::ST_IDLE);
		out_valid      = (state_q == lzs_pkg::ST_EMIT_OUT);
		elem_we        = in_acc && room;
		key_ctrl.wr_en = key_ins;
		key_ctrl.clear = out_acc && eor_q;
		unique case (state_q)
			lzs_pkg::ST_SCAN: key_rd_addr = k_next[IDX_BITS-1:0];
			default:          key_rd_addr = '0;
		endcase
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lzs_pkg::ST_IDLE;
			sum_q      <= '0;
			count_q    <= '0;
			best_q     <= '0;
			best_end_q <= '0;
			last_q     <= 1'b0;
			has_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lzs_pkg::ST_IDLE: begin
					if (in_acc) begin
						last_q <= last;
						if (room) begin
							sum_q <= sum_q + value_ext;
						end
					end
				end
				lzs_pkg::ST_UPDATE: begin
					has_q <= sum_zero;
				end
				lzs_pkg::ST_SCAN: begin
					has_q <= hit;
				end
				lzs_pkg::ST_BEST: begin
					// strictly longer only, so a tie keeps the earlier span
					if (has_q && len_q > best_q) begin
						best_q     <= len_q;
						best_end_q <= cur_idx;
					end
					count_q <= count_q + ONE_CNT;
				end
				lzs_pkg::ST_EMIT_OUT: begin
					// run done: clear for the next array
					if (!out_stall && eor_q) begin
						sum_q      <= '0;
						count_q    <= '0;
						best_q     <= '0;
						best_end_q <= '0;
						last_q     <= 1'b0;
						has_q      <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers: scan index, span length, emit pointer, output request
	always_ff @(posedge clk) begin
		unique case (state_q)
			lzs_pkg::ST_UPDATE: begin
				k_q   <= '0;
				len_q <= count_q + ONE_CNT;
			end
			lzs_pkg::ST_SCAN: begin
				len_q <= count_q - CNT_BITS'(k_q);
				k_q   <= k_next[IDX_BITS-1:0];
			end
			lzs_pkg::ST_EMIT_START: begin
				// not-found request carries all ones
				ptr_q       <= start_cnt[IDX_BITS-1:0];
				value_res_q <= '1;
				found_q     <= 1'b0;
				eor_q       <= 1'b1;
			end
			lzs_pkg::ST_EMIT_LD: begin
				value_res_q <= elem_rd_data;
				found_q     <= 1'b1;
				eor_q       <= (ptr_q == best_end_q);
			end
			lzs_pkg::ST_EMIT_OUT: begin
				if (!out_stall) begin
					ptr_q <= ptr_q + IDX_BITS'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign value_res  = value_res_q;
	assign found      = found_q;
	assign end_of_run = eor_q;

	// prefix sum table with shared comparator
	lzs_key_table #(
		.DEPTH    (MAX_LEN),
		.IDX_BITS (IDX_BITS),
		.KEY_BITS (SUM_BITS)
	) u_key_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (key_ctrl),
		.wr_addr   (cur_idx),
		.wr_key    (sum_q),
		.rd_addr   (key_rd_addr),
		.probe_key (sum_q),
		.hit       (hit)
	);

	// stored elements for the emitted span
	lzs_elem_store #(
		.DEPTH     (MAX_LEN),
		.IDX_BITS  (IDX_BITS),
		.DATA_BITS (VALUE_BITS)
	) u_elem_store (
		.clk     (clk),
		.we      (elem_we),
		.wr_addr (cur_idx),
		.wr_data (value),
		.rd_addr (ptr_q),
		.rd_data (elem_rd_data)
	);

`ifndef NO_ASSERTIONS
	// element count never passes the array limit
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("element count beyond limit");

	// best span never longer than the elements taken
	a_best_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= count_q)
		else $error("best span longer than element count");

	// emit pointer stays inside the best span
	a_ptr_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lzs_pkg::ST_EMIT_RD) |-> (ptr_q <= best_end_q && best_q != '0))
		else $error("emit pointer outside best span");

	// not-found request only when no span exists, and it closes the run
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (end_of_run && best_q == '0))
		else $error("bad not-found request");

	// last request of a run clears the array state
	a_clear_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && end_of_run) |=>
			(count_q == '0 && best_q == '0 && state_q == lzs_pkg::ST_IDLE))
		else $error("state not cleared after run");
`endif

endmodule
